FILE: rtl/mbpv_pkg.sv
// shared types and constants for the msb-first bit packer with vlq encoding
package mbpv_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_VLQ   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // widths of the packing datapath
    localparam int unsigned MAX_FIELD_BITS = 32;
    localparam int unsigned ACC_W          = 40;
    localparam int unsigned TOT_W          = 6;
    localparam int unsigned REM_W          = 25;

    localparam logic [TOT_W-1:0] FIELD_MAX  = 6'd32;
    localparam logic [TOT_W-1:0] BYTE_BITS  = 6'd8;
    localparam logic [TOT_W-1:0] ACC_BITS   = 6'd40;
    localparam logic [7:0]       GROUP_MASK = 8'h7f;
    localparam logic [7:0]       GROUP_MORE = 8'h80;

    // one input item
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
        logic [5:0]  bit_count;
    } item_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // request to the shared load unit
    typedef struct packed {
        logic [6:0]       pend_bits;
        logic [2:0]       pend_count;
        logic [31:0]      bits;
        logic [TOT_W-1:0] count;
    } load_req_t;

    // accumulator produced by the shared load unit
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [TOT_W-1:0] total;
    } load_res_t;

endpackage

FILE: rtl/mbpv_load.sv
// shared load unit: masks a field and places it after the pending bits, msb aligned
module mbpv_load (
    input  mbpv_pkg::load_req_t req,
    output mbpv_pkg::load_res_t res
);

    logic [32:0]                      mask;
    logic [31:0]                      bits_masked;
    logic [mbpv_pkg::TOT_W-1:0]       shamt;
    logic [mbpv_pkg::ACC_W-1:0]       field;
    logic [mbpv_pkg::ACC_W-1:0]       pend;

    // keep only the low count bits of the field
    always_comb
    begin
        mask        = (33'd1 << req.count) - 33'd1;
        bits_masked = req.bits & mask[31:0];
    end

    // field ends right below the pending bits plus its own length
    always_comb
    begin
        shamt = mbpv_pkg::ACC_BITS - {3'b000, req.pend_count} - req.count;
        field = {8'h00, bits_masked} << shamt;
        pend  = {req.pend_bits, 33'd0};
        res.acc   = pend | field;
        res.total = {3'b000, req.pend_count} + req.count;
    end

endmodule

FILE: rtl/msb_first_bit_packer_vlq.sv
// top level: packs fields and vlq quantities msb first; one byte per cycle unless stalled
// Each accepted write or vlq is loaded into a 40-bit msb-aligned accumulator in its accept
// cycle by one shared mask-and-shift unit; the sequencer then emits one completed byte per
// cycle into the output register while stall is low. A write emits 0 to 4 completed bytes,
// a vlq one byte per 7-bit group (1 to 5), the next group being reloaded through the same
// unit as the previous byte leaves, and a flush one byte if bits are pending. An item that
// emits nothing leaves the block ready in the next cycle. The last result of an item
// carries last set; the pending partial byte persists between items until a flush.
module msb_first_bit_packer_vlq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mbpv_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mbpv_pkg::result_t result
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [mbpv_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [mbpv_pkg::TOT_W-1:0]      tot_reg, tot_next;
    logic [mbpv_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic                            vlq_reg, vlq_next;
    logic                            out_valid_reg, out_valid_next;
    mbpv_pkg::result_t               out_data_reg, out_data_next;

    mbpv_pkg::load_req_t             load_req;
    mbpv_pkg::load_res_t             load_res;

    logic                            accept;
    logic                            out_free;
    logic [mbpv_pkg::ACC_W-1:0]      acc_shift;
    logic [mbpv_pkg::TOT_W-1:0]      tot_dec;
    logic                            more_group;
    logic                            group_end;
    logic                            byte_last;
    logic [mbpv_pkg::TOT_W-1:0]      field_count;
    logic                            first_more;

    // handshake
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // emit step: drop the top byte of the accumulator
    always_comb
    begin
        acc_shift  = {acc_reg[mbpv_pkg::ACC_W-9:0], 8'h00};
        tot_dec    = tot_reg - mbpv_pkg::BYTE_BITS;
        more_group = vlq_reg && (rem_reg != '0);
        group_end  = (tot_dec < mbpv_pkg::BYTE_BITS);
        byte_last  = group_end && !more_group;
    end

    // field length saturates at 32 bits
    always_comb
    begin
        field_count = (item.bit_count > mbpv_pkg::FIELD_MAX) ? mbpv_pkg::FIELD_MAX
                                                             : item.bit_count;
        first_more  = (item.value[31:7] != '0);
    end

    // request mux for the shared load unit
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            load_req.pend_bits  = acc_reg[mbpv_pkg::ACC_W-1:mbpv_pkg::ACC_W-7];
            load_req.pend_count = tot_reg[2:0];
            if (item.command == mbpv_pkg::CMD_VLQ)
            begin
                load_req.bits  = {24'd0,
                                  (item.value[7:0] & mbpv_pkg::GROUP_MASK)
                                  | (first_more ? mbpv_pkg::GROUP_MORE : 8'h00)};
                load_req.count = mbpv_pkg::BYTE_BITS;
            end
            else
            begin
                load_req.bits  = item.value;
                load_req.count = field_count;
            end
        end
        else
        begin
            load_req.pend_bits  = acc_shift[mbpv_pkg::ACC_W-1:mbpv_pkg::ACC_W-7];
            load_req.pend_count = tot_dec[2:0];
            load_req.bits       = {24'd0,
                                   (rem_reg[7:0] & mbpv_pkg::GROUP_MASK)
                                   | ((rem_reg[mbpv_pkg::REM_W-1:7] != '0)
                                      ? mbpv_pkg::GROUP_MORE : 8'h00)};
            load_req.count      = mbpv_pkg::BYTE_BITS;
        end
    end

    mbpv_load u_load (
        .req (load_req),
        .res (load_res)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        tot_next       = tot_reg;
        rem_next       = rem_reg;
        vlq_next       = vlq_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.command)
                        mbpv_pkg::CMD_WRITE:
                        begin
                            acc_next   = load_res.acc;
                            tot_next   = load_res.total;
                            vlq_next   = 1'b0;
                            if (load_res.total >= mbpv_pkg::BYTE_BITS)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        mbpv_pkg::CMD_VLQ:
                        begin
                            acc_next   = load_res.acc;
                            tot_next   = load_res.total;
                            rem_next   = item.value[31:7];
                            vlq_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                        mbpv_pkg::CMD_FLUSH:
                        begin
                            // pending bits are already msb aligned with zeros below
                            if (tot_reg[2:0] != 3'd0)
                            begin
                                tot_next   = mbpv_pkg::BYTE_BITS;
                                vlq_next   = 1'b0;
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            // unused code: item ignored
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.out_byte = acc_reg[mbpv_pkg::ACC_W-1:mbpv_pkg::ACC_W-8];
                    out_data_next.last     = byte_last;
                    if (more_group && group_end)
                    begin
                        // reload the next vlq group behind the remaining bits
                        acc_next = load_res.acc;
                        tot_next = load_res.total;
                        rem_next = rem_reg >> 7;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        tot_next = tot_dec;
                        if (group_end)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            tot_reg       <= '0;
            rem_reg       <= '0;
            vlq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            tot_reg       <= tot_next;
            rem_reg       <= rem_next;
            vlq_reg       <= vlq_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

FILE: sim/mbpv_checker.sv
// checker for the bit packer: predicts the packed byte stream and compares each result item
module mbpv_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  mbpv_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  mbpv_pkg::result_t result,
    output int                mismatch_count,
    output int                bytes_outstanding
);
    import mbpv_pkg::*;

    // predicted copy of the pending partial byte
    logic [6:0] pend_bits;
    logic [2:0] pend_count;

    // bytes completed by the item being predicted, and the stream still awaited
    logic [7:0] new_bytes[$];
    result_t    expected_bytes[$];

    // append the low n bits of v after the pending bits, collecting full bytes
    task automatic pack_field(input logic [31:0] v, input int unsigned n);
        logic [39:0] acc;
        int unsigned total;
        if (n == 0)
            return;
        if (n > MAX_FIELD_BITS)
            n = MAX_FIELD_BITS;
        acc = ({33'd0, pend_bits} << n) | ({8'd0, v} & ((40'd1 << n) - 40'd1));
        total = pend_count + n;
        while (total >= 8)
        begin
            total -= 8;
            new_bytes.push_back(8'(acc >> total));
        end
        pend_bits  = 7'(acc & ((40'd1 << total) - 40'd1));
        pend_count = 3'(total);
    endtask

    // work out the bytes an accepted item produces and queue them in stream order
    task automatic predict_packed_bytes(input item_t it);
        logic [31:0] rest;
        logic [7:0]  grp;
        logic [15:0] padded;
        result_t     r;
        new_bytes.delete();
        case (it.command)
            CMD_WRITE:
            begin
                pack_field(it.value, it.bit_count);
            end
            CMD_VLQ:
            begin
                // seven bits per group, low group first, top bit marks more to come
                rest = it.value;
                do
                begin
                    grp  = rest[7:0] & GROUP_MASK;
                    rest = rest >> 7;
                    if (rest != 0)
                        grp = grp | GROUP_MORE;
                    pack_field({24'd0, grp}, 8);
                end
                while (rest != 0);
            end
            CMD_FLUSH:
            begin
                if (pend_count != 0)
                begin
                    padded = {9'd0, pend_bits} << (8 - pend_count);
                    new_bytes.push_back(padded[7:0]);
                end
                pend_bits  = '0;
                pend_count = '0;
            end
            default:
            begin
                // unused code: nothing emitted, state kept
            end
        endcase
        foreach (new_bytes[i])
        begin
            r.out_byte = new_bytes[i];
            r.last     = (i == new_bytes.size() - 1);
            expected_bytes.push_back(r);
        end
    endtask

    // compare results with the oldest expectation, then predict the accepted item
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        int      errs;
        if (!rst_n)
        begin
            pend_bits  = '0;
            pend_count = '0;
            expected_bytes.delete();
            mismatch_count    <= 0;
            bytes_outstanding <= 0;
        end
        else
        begin
            errs = mismatch_count;
            if (result_valid && !result_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got byte %02h last %0b",
                             $time, result.out_byte, result.last);
                    errs++;
                end
                else
                begin
                    exp_r = expected_bytes.pop_front();
                    if (result.out_byte !== exp_r.out_byte)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, exp_r.out_byte, result.out_byte);
                        errs++;
                    end
                    if (result.last !== exp_r.last)
                    begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, exp_r.last, result.last);
                        errs++;
                    end
                end
            end
            if (item_valid && !item_stall)
                predict_packed_bytes(item);
            mismatch_count    <= errs;
            bytes_outstanding <= expected_bytes.size();
        end
    end

endmodule

FILE: sim/tb.sv
// testbench top: drives items into the bit packer, stalls the result side and reports the verdict
module tb;
    import mbpv_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_ITEMS = 300;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    gaps_on;
    int      mismatch_count;
    int      bytes_outstanding;
    int      cycles;

    msb_first_bit_packer_vlq u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    mbpv_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    // clock and known inputs from time zero
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        gaps_on      = 1'b1;
        cycles       = 0;
    end

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // random stall on the result side
    always @(posedge clk)
    begin
        if (rst_n)
            result_stall <= gaps_on && ($urandom_range(99) < 10);
    end

    function automatic item_t make_item(input logic [1:0] cmd, input logic [31:0] val,
                                        input logic [5:0] cnt);
        item_t it;
        it.command   = cmd;
        it.value     = val;
        it.bit_count = cnt;
        return it;
    endfunction

    // offer one item, with an occasional gap before it, and hold it until taken
    task automatic send_item(input item_t it);
        if (gaps_on && $urandom_range(99) < 10)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // stimulus and verdict
    initial
    begin
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] val;
        logic [5:0]  cnt;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each command, saturation and the unused code
        send_item(make_item(CMD_WRITE, 32'hffff_ffff, 6'd0));
        send_item(make_item(CMD_WRITE, 32'h0000_0001, 6'd1));
        send_item(make_item(CMD_WRITE, 32'h0000_007f, 6'd7));
        send_item(make_item(CMD_WRITE, 32'hffff_ffff, 6'd32));
        send_item(make_item(CMD_WRITE, 32'h0000_0000, 6'd32));
        send_item(make_item(CMD_WRITE, 32'hffff_fff5, 6'd5));
        send_item(make_item(CMD_WRITE, 32'hffff_ffff, 6'd33));
        send_item(make_item(CMD_WRITE, 32'ha5a5_a5a5, 6'd63));
        send_item(make_item(CMD_FLUSH, 32'hffff_ffff, 6'd63));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(CMD_WRITE, 32'h0000_00c3, 6'd8));
        send_item(make_item(CMD_VLQ,   32'h0000_0000, 6'd0));
        send_item(make_item(CMD_VLQ,   32'h0000_007f, 6'd0));
        send_item(make_item(CMD_VLQ,   32'h0000_0080, 6'd63));
        send_item(make_item(CMD_VLQ,   32'h0000_3fff, 6'd0));
        send_item(make_item(CMD_VLQ,   32'h0000_4000, 6'd0));
        send_item(make_item(CMD_VLQ,   32'hffff_ffff, 6'd0));
        send_item(make_item(CMD_WRITE, 32'h0000_0005, 6'd3));
        send_item(make_item(CMD_VLQ,   32'h1234_5678, 6'd0));
        send_item(make_item(CMD_UNUSED, 32'hffff_ffff, 6'd63));
        send_item(make_item(CMD_VLQ,   32'hffff_ffff, 6'd0));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));
        send_item(make_item(CMD_WRITE, 32'h0000_0001, 6'd1));
        send_item(make_item(CMD_FLUSH, 32'h0000_0000, 6'd0));

        // random mix, with a stretch in the middle free of gaps and stalls
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 120)
                gaps_on <= 1'b0;
            if (i == 220)
                gaps_on <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 50)
                cmd = CMD_WRITE;
            else if (pick < 80)
                cmd = CMD_VLQ;
            else if (pick < 95)
                cmd = CMD_FLUSH;
            else
                cmd = CMD_UNUSED;
            if (cmd == CMD_VLQ)
                val = $urandom >> $urandom_range(0, 31);
            else
                val = $urandom;
            if ($urandom_range(99) < 8)
                cnt = 6'($urandom_range(33, 63));
            else
                cnt = 6'($urandom_range(0, 32));
            send_item(make_item(cmd, val, cnt));
        end
        item_valid <= 1'b0;

        // drain, then wait on so that any stray result from the block still shows
        @(posedge clk);
        while (bytes_outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
